// ===== rtl/lpmf_pkg.sv =====
package lpmf_pkg;

  // Field widths of the stream items.
  localparam int INDEX_W = 12;
  localparam int COUNT_W = 13;
  localparam int RANGE_W = 15;
  localparam int INTEN_W = 8;
  localparam int RANGE_OUT_W = 16;
  localparam int IN_TDATA_W = 48;
  localparam int OUT_TDATA_W = 40;
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;

  // Register map, word index inside the APB window.
  localparam logic [2:0] REG_WINDOW_A = 3'd0;
  localparam logic [2:0] REG_WINDOW_B = 3'd1;
  localparam logic [2:0] REG_WINDOW_C = 3'd2;
  localparam logic [2:0] REG_WINDOW_D = 3'd3;
  localparam logic [2:0] REG_WINDOW_E = 3'd4;
  localparam logic [2:0] REG_BODY_RADIUS = 3'd5;
  localparam logic [2:0] REG_BODY_CENTER = 3'd6;
  localparam logic [2:0] REG_ANGLE_STEP = 3'd7;
  localparam int WIN_REGS = 5;

  // Reset values of the configuration registers.
  localparam logic [10:0] RADIUS_RESET = 11'd200;
  localparam logic [11:0] STEP_RESET = 12'd100;

  // Filter constants.
  localparam logic [RANGE_OUT_W-1:0] NO_RETURN = 16'hFFFF;
  localparam logic [RANGE_W-1:0] NEAR_MM = 15'd60;
  localparam logic [RANGE_W-1:0] FAR_MM = 15'd1000;
  localparam int FULL_TENTHS = 3600;
  localparam int FULL_CD = 36000;
  localparam int QUAD_CD = 9000;

  // Reciprocals for division by constants (floor or ceiling, see use).
  localparam int MOD_RECIP = 477218;   // floor(2^34 / 36000)
  localparam int MOD_SHIFT = 34;
  localparam int DIV100_U = 5243;      // ceil(2^19 / 100), exact for u < 43690
  localparam int DIV100_U_SHIFT = 19;
  localparam int DIV100_N = 83887;     // ceil(2^23 / 100), exact for n < 91180
  localparam int DIV100_N_SHIFT = 23;
  localparam int ROUND_HALF = 50;

  // Pipeline stage numbers of the top level.
  localparam int ST_SLOT = 1;
  localparam int ST_MASK = 3;
  localparam int ST_TRIG = 13;
  localparam int ST_HIT = 17;
  localparam int ST_OUT = 18;
  localparam int NUM_STAGES = 19;
  localparam int WIN_DEPTH = ST_MASK - ST_SLOT;
  localparam int TRIG_DEPTH = ST_TRIG - ST_SLOT;
  localparam int QTR_DEPTH = 5;
  localparam int QTR_FIRST = 6;
  localparam int BODY_DEPTH = ST_HIT - ST_TRIG;

  typedef struct packed {
    logic [INTEN_W-1:0] intensity;
    logic [RANGE_W-1:0] range_mm;
    logic [COUNT_W-1:0] point_count;
    logic [INDEX_W-1:0] point_index;
  } point_t;

  typedef struct packed {
    logic [INTEN_W-1:0] intensity_out;
    logic [RANGE_OUT_W-1:0] range_out_mm;
    logic [INDEX_W-1:0] slot_index;
  } result_t;

  typedef struct packed {
    logic [INDEX_W-1:0] slot;
    logic [RANGE_W-1:0] range_mm;
    logic [INTEN_W-1:0] intensity;
    logic masked;
  } carry_t;

  // Quarter-wave sine in Q1.15, one entry per whole degree.
  // Index 91 only appears with a zero fraction and reads full scale.
  function automatic logic [15:0] quarter_sine(input logic [6:0] deg);
    logic [15:0] v;
    case (deg)
      7'd0: v = 16'd0;       7'd1: v = 16'd572;     7'd2: v = 16'd1144;
      7'd3: v = 16'd1715;    7'd4: v = 16'd2286;    7'd5: v = 16'd2856;
      7'd6: v = 16'd3425;    7'd7: v = 16'd3993;    7'd8: v = 16'd4560;
      7'd9: v = 16'd5126;    7'd10: v = 16'd5690;   7'd11: v = 16'd6252;
      7'd12: v = 16'd6813;   7'd13: v = 16'd7371;   7'd14: v = 16'd7927;
      7'd15: v = 16'd8481;   7'd16: v = 16'd9032;   7'd17: v = 16'd9580;
      7'd18: v = 16'd10126;  7'd19: v = 16'd10668;  7'd20: v = 16'd11207;
      7'd21: v = 16'd11743;  7'd22: v = 16'd12275;  7'd23: v = 16'd12803;
      7'd24: v = 16'd13328;  7'd25: v = 16'd13848;  7'd26: v = 16'd14365;
      7'd27: v = 16'd14876;  7'd28: v = 16'd15384;  7'd29: v = 16'd15886;
      7'd30: v = 16'd16384;  7'd31: v = 16'd16877;  7'd32: v = 16'd17364;
      7'd33: v = 16'd17847;  7'd34: v = 16'd18324;  7'd35: v = 16'd18795;
      7'd36: v = 16'd19261;  7'd37: v = 16'd19720;  7'd38: v = 16'd20174;
      7'd39: v = 16'd20622;  7'd40: v = 16'd21063;  7'd41: v = 16'd21498;
      7'd42: v = 16'd21926;  7'd43: v = 16'd22348;  7'd44: v = 16'd22763;
      7'd45: v = 16'd23170;  7'd46: v = 16'd23571;  7'd47: v = 16'd23965;
      7'd48: v = 16'd24351;  7'd49: v = 16'd24730;  7'd50: v = 16'd25102;
      7'd51: v = 16'd25466;  7'd52: v = 16'd25822;  7'd53: v = 16'd26170;
      7'd54: v = 16'd26510;  7'd55: v = 16'd26842;  7'd56: v = 16'd27166;
      7'd57: v = 16'd27482;  7'd58: v = 16'd27789;  7'd59: v = 16'd28088;
      7'd60: v = 16'd28378;  7'd61: v = 16'd28660;  7'd62: v = 16'd28932;
      7'd63: v = 16'd29197;  7'd64: v = 16'd29452;  7'd65: v = 16'd29698;
      7'd66: v = 16'd29935;  7'd67: v = 16'd30163;  7'd68: v = 16'd30382;
      7'd69: v = 16'd30592;  7'd70: v = 16'd30792;  7'd71: v = 16'd30983;
      7'd72: v = 16'd31164;  7'd73: v = 16'd31336;  7'd74: v = 16'd31499;
      7'd75: v = 16'd31651;  7'd76: v = 16'd31795;  7'd77: v = 16'd31928;
      7'd78: v = 16'd32052;  7'd79: v = 16'd32166;  7'd80: v = 16'd32270;
      7'd81: v = 16'd32365;  7'd82: v = 16'd32449;  7'd83: v = 16'd32524;
      7'd84: v = 16'd32588;  7'd85: v = 16'd32643;  7'd86: v = 16'd32688;
      7'd87: v = 16'd32723;  7'd88: v = 16'd32748;  7'd89: v = 16'd32763;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/lpmf_window.sv =====
module lpmf_window
  import lpmf_pkg::*;
#(
  parameter int NUM_WINDOWS = 5
) (
  input  logic                          clk,
  input  logic [WIN_DEPTH-1:0]          stage_en,
  input  logic [INDEX_W-1:0]            slot,
  input  logic [COUNT_W-1:0]            count,
  input  logic [NUM_WINDOWS-1:0][31:0]  windows,
  output logic                          masked
);

  logic [23:0] pos;
  logic [28:0] lo_bound [NUM_WINDOWS];
  logic [28:0] hi_bound [NUM_WINDOWS];
  logic [NUM_WINDOWS-1:0] active;
  logic [NUM_WINDOWS-1:0] inside_win;

  // First stage: scale the slot by a full turn in tenths and both window edges by the point count.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      pos <= 24'(slot) * 24'(FULL_TENTHS);
    end
  end

  for (genvar w = 0; w < NUM_WINDOWS; w++) begin : g_lane
    always_ff @(posedge clk) begin
      if (stage_en[0]) begin
        lo_bound[w] <= 29'(windows[w][15:0]) * 29'(count);
        hi_bound[w] <= 29'(windows[w][31:16]) * 29'(count);
        active[w] <= windows[w][31:16] > windows[w][15:0];
      end
    end

    assign inside_win[w] = active[w] && (29'(pos) >= lo_bound[w]) &&
                           (29'(pos) < hi_bound[w]);
  end

  // Second stage: the point is masked when any enabled window holds it.
  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      masked <= |inside_win;
    end
  end

endmodule

// ===== rtl/lpmf_quarter.sv =====
module lpmf_quarter
  import lpmf_pkg::*;
(
  input  logic                 clk,
  input  logic [QTR_DEPTH-1:0] stage_en,
  input  logic [13:0]          u,
  output logic [15:0]          mag
);

  logic [26:0] d_prod;
  logic [6:0]  deg;
  logic [13:0] u_d;
  logic [6:0]  frac;
  logic [15:0] lo1;
  logic [15:0] hi1;
  logic [9:0]  diff;
  logic [15:0] num;
  logic [15:0] lo2;
  logic [32:0] q_prod;
  logic [9:0]  q100;
  logic [15:0] lo3;

  assign d_prod = 27'(u) * 27'(DIV100_U);
  assign diff = 10'(hi1 - lo1);
  assign q_prod = 33'(num) * 33'(DIV100_N);

  // Split centidegrees into whole degrees and a fraction, look up both
  // neighbors, then interpolate with round-half-up division by 100.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      deg <= d_prod[DIV100_U_SHIFT +: 7];
      u_d <= u;
    end
    if (stage_en[1]) begin
      frac <= 7'(u_d - 14'(deg) * 14'd100);
      lo1 <= quarter_sine(deg);
      hi1 <= quarter_sine(deg + 7'd1);
    end
    if (stage_en[2]) begin
      num <= 16'({6'b0, diff} * {9'b0, frac} + 16'(ROUND_HALF));
      lo2 <= lo1;
    end
    if (stage_en[3]) begin
      q100 <= q_prod[DIV100_N_SHIFT +: 10];
      lo3 <= lo2;
    end
    if (stage_en[4]) begin
      mag <= lo3 + 16'(q100);
    end
  end

endmodule

// ===== rtl/lpmf_sincos.sv =====
module lpmf_sincos
  import lpmf_pkg::*;
(
  input  logic                  clk,
  input  logic [TRIG_DEPTH-1:0] stage_en,
  input  logic [INDEX_W-1:0]    slot,
  input  logic [11:0]           step,
  output logic signed [16:0]    sin_q15,
  output logic signed [16:0]    cos_q15
);

  logic [23:0] angle_raw;
  logic [23:0] angle_hold;
  logic [42:0] quot_prod;
  logic [8:0]  quot;
  logic [16:0] rem_coarse;
  logic [15:0] angle;
  logic [1:0]  quad_c;
  logic [13:0] rem_c;
  logic [1:0]  quad;
  logic [1:0]  quad_cos;
  logic [13:0] rem;
  logic [13:0] u_sin;
  logic [13:0] u_cos;
  logic [QTR_DEPTH:0] neg_sin;
  logic [QTR_DEPTH:0] neg_cos;
  logic [15:0] mag_sin;
  logic [15:0] mag_cos;

  assign quot_prod = 43'(angle_raw) * 43'(MOD_RECIP);
  assign quad_cos = quad + 2'd1;

  // Quadrant of the reduced angle and the offset inside it.
  always_comb begin
    if (angle >= 16'(3 * QUAD_CD)) begin
      quad_c = 2'd3;
      rem_c = 14'(angle - 16'(3 * QUAD_CD));
    end else if (angle >= 16'(2 * QUAD_CD)) begin
      quad_c = 2'd2;
      rem_c = 14'(angle - 16'(2 * QUAD_CD));
    end else if (angle >= 16'(QUAD_CD)) begin
      quad_c = 2'd1;
      rem_c = 14'(angle - 16'(QUAD_CD));
    end else begin
      quad_c = 2'd0;
      rem_c = 14'(angle);
    end
  end

  // Angle reduction modulo a full turn: the reciprocal estimate is at most
  // one short, so one conditional subtract finishes it.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      angle_raw <= 24'(slot) * 24'(step);
    end
    if (stage_en[1]) begin
      angle_hold <= angle_raw;
      quot <= quot_prod[MOD_SHIFT +: 9];
    end
    if (stage_en[2]) begin
      rem_coarse <= 17'(angle_hold - 24'(quot) * 24'(FULL_CD));
    end
    if (stage_en[3]) begin
      angle <= (rem_coarse >= 17'(FULL_CD)) ? 16'(rem_coarse - 17'(FULL_CD))
                                            : 16'(rem_coarse);
    end
    if (stage_en[4]) begin
      quad <= quad_c;
      rem <= rem_c;
    end
    // Odd quadrants run the table backwards; cosine is one quadrant ahead.
    if (stage_en[5]) begin
      u_sin <= quad[0] ? 14'(QUAD_CD) - rem : rem;
      u_cos <= quad_cos[0] ? 14'(QUAD_CD) - rem : rem;
      neg_sin[0] <= quad[1];
      neg_cos[0] <= quad_cos[1];
    end
  end

  // Sign bits ride along with the table lookup, one register per stage.
  for (genvar i = 1; i <= QTR_DEPTH; i++) begin : g_sign
    always_ff @(posedge clk) begin
      if (stage_en[QTR_FIRST + i - 1]) begin
        neg_sin[i] <= neg_sin[i-1];
        neg_cos[i] <= neg_cos[i-1];
      end
    end
  end

  lpmf_quarter u_qsin (
    .clk      (clk),
    .stage_en (stage_en[QTR_FIRST +: QTR_DEPTH]),
    .u        (u_sin),
    .mag      (mag_sin)
  );

  lpmf_quarter u_qcos (
    .clk      (clk),
    .stage_en (stage_en[QTR_FIRST +: QTR_DEPTH]),
    .u        (u_cos),
    .mag      (mag_cos)
  );

  // Apply the quadrant sign.
  always_ff @(posedge clk) begin
    if (stage_en[TRIG_DEPTH-1]) begin
      sin_q15 <= neg_sin[QTR_DEPTH] ? -$signed({1'b0, mag_sin})
                                    : $signed({1'b0, mag_sin});
      cos_q15 <= neg_cos[QTR_DEPTH] ? -$signed({1'b0, mag_cos})
                                    : $signed({1'b0, mag_cos});
    end
  end

endmodule

// ===== rtl/lpmf_body.sv =====
module lpmf_body
  import lpmf_pkg::*;
(
  input  logic                  clk,
  input  logic [BODY_DEPTH-1:0] stage_en,
  input  logic [RANGE_W-1:0]    range_mm,
  input  logic signed [16:0]    sin_q15,
  input  logic signed [16:0]    cos_q15,
  input  logic [31:0]           center,
  input  logic [10:0]           radius,
  output logic                  hit
);

  logic signed [32:0] x_pos;
  logic signed [32:0] y_pos;
  logic signed [33:0] dx;
  logic signed [33:0] dy;
  logic [21:0] rad_sq1;
  logic [21:0] rad_sq2;
  logic signed [26:0] dx_n;
  logic signed [26:0] dy_n;
  logic signed [53:0] dx_sq_full;
  logic signed [53:0] dy_sq_full;
  logic [52:0] dx_sq;
  logic [52:0] dy_sq;
  logic fit_x;
  logic fit_y;
  logic [53:0] dist_sq;

  assign dx_n = dx[26:0];
  assign dy_n = dy[26:0];
  assign dx_sq_full = dx_n * dx_n;
  assign dy_sq_full = dy_n * dy_n;
  assign dist_sq = {1'b0, dx_sq} + {1'b0, dy_sq};

  // Point position, offset from the body center, squared distance, compare.
  // An offset that does not fit in 27 signed bits is already outside any
  // radius the register can hold.
  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      x_pos <= $signed({1'b0, range_mm}) * cos_q15;
      y_pos <= $signed({1'b0, range_mm}) * sin_q15;
    end
    if (stage_en[1]) begin
      dx <= $signed({x_pos[32], x_pos} - {{3{center[15]}}, center[15:0], 15'b0});
      dy <= $signed({y_pos[32], y_pos} - {{3{center[31]}}, center[31:16], 15'b0});
      rad_sq1 <= 22'(radius) * 22'(radius);
    end
    if (stage_en[2]) begin
      fit_x <= (dx[33:26] == 8'h00) || (dx[33:26] == 8'hFF);
      fit_y <= (dy[33:26] == 8'h00) || (dy[33:26] == 8'hFF);
      dx_sq <= dx_sq_full[52:0];
      dy_sq <= dy_sq_full[52:0];
      rad_sq2 <= rad_sq1;
    end
    if (stage_en[3]) begin
      hit <= fit_x && fit_y && (dist_sq < {2'b0, rad_sq2, 30'b0});
    end
  end

endmodule

// ===== rtl/lidar_point_mask_filter.sv =====
// Lidar point mask filter.
//
// Points of a scan enter on the s_axis stream, one transfer per point, and
// leave on the m_axis stream in the same order, one result per point. The
// result carries the mirrored slot number and the filtered range and
// intensity: zero range or a hit in a disable window gives no-return with
// intensity zero, and a near point inside the robot body circle gives
// no-return with its intensity kept.
// The pipeline depth is set by the angle reduction, the interpolated sine
// and cosine lookup and the squared distance check. Throughput is one point
// per cycle while the receiver takes the results.
// Every stage has its own valid bit and moves when the stage after it has
// room, so bubbles close up and s_axis_tready stays high until all stages
// hold a point while the receiver stalls. A stalled result holds its data.
// The APB port sets the windows, body radius and center, and angle step;
// write it only while no point is in flight. Reset empties the pipeline and
// returns the registers to their defaults.
module lidar_point_mask_filter
  import lpmf_pkg::*;
#(
  parameter int MAX_POINTS = 4096,
  parameter int NUM_WINDOWS = 5
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // point_index, point_count, range_mm, intensity
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // slot_index, range_out_mm, intensity_out, zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int CNT_CAP = (MAX_POINTS > (2**COUNT_W - 1)) ? (2**COUNT_W - 1)
                                                             : MAX_POINTS;

  logic [WIN_REGS-1:0][31:0] win_reg;
  logic [10:0] radius_reg;
  logic [31:0] center_reg;
  logic [11:0] step_reg;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES-1:0] en;

  point_t in_q;
  logic [COUNT_W-1:0] count_sat;
  logic [COUNT_W-1:0] count1;
  logic [INDEX_W-1:0] slot_c;
  carry_t car [ST_SLOT:ST_HIT];

  logic mask_w;
  logic hit_w;
  logic signed [16:0] sin_w;
  logic signed [16:0] cos_w;
  logic near;
  result_t res_c;
  result_t out_q;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      win_reg <= '0;
      radius_reg <= RADIUS_RESET;
      center_reg <= '0;
      step_reg <= STEP_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_A: win_reg[0] <= pwdata;
        REG_WINDOW_B: win_reg[1] <= pwdata;
        REG_WINDOW_C: win_reg[2] <= pwdata;
        REG_WINDOW_D: win_reg[3] <= pwdata;
        REG_WINDOW_E: win_reg[4] <= pwdata;
        REG_BODY_RADIUS: radius_reg <= pwdata[10:0];
        REG_BODY_CENTER: center_reg <= pwdata;
        REG_ANGLE_STEP: step_reg <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_A: prdata = win_reg[0];
      REG_WINDOW_B: prdata = win_reg[1];
      REG_WINDOW_C: prdata = win_reg[2];
      REG_WINDOW_D: prdata = win_reg[3];
      REG_WINDOW_E: prdata = win_reg[4];
      REG_BODY_RADIUS: prdata = 32'(radius_reg);
      REG_BODY_CENTER: prdata = center_reg;
      REG_ANGLE_STEP: prdata = 32'(step_reg);
      default: prdata = '0;
    endcase
  end

  // A stage loads when it is empty or when the stage after it moves.
  assign en[ST_OUT] = !valid[ST_OUT] || m_axis_tready;
  for (genvar k = 0; k < ST_OUT; k++) begin : g_en
    assign en[k] = !valid[k] || en[k+1];
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid[ST_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      in_q <= point_t'(s_axis_tdata);
    end
  end

  // Saturate the count and mirror the index into the output slot.
  assign count_sat = (in_q.point_count > COUNT_W'(CNT_CAP)) ? COUNT_W'(CNT_CAP)
                                                             : in_q.point_count;
  assign slot_c = count_sat[INDEX_W-1:0] - INDEX_W'(1) - in_q.point_index;

  always_ff @(posedge clk) begin
    if (en[ST_SLOT]) begin
      count1 <= count_sat;
      car[ST_SLOT].slot <= slot_c;
      car[ST_SLOT].range_mm <= in_q.range_mm;
      car[ST_SLOT].intensity <= in_q.intensity;
      car[ST_SLOT].masked <= 1'b0;
    end
  end

  // Shift line for the fields that pass through untouched, and for the mask flag from the window check.
  for (genvar k = ST_SLOT + 1; k <= ST_HIT; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[k]) begin
        car[k].slot <= car[k-1].slot;
        car[k].range_mm <= car[k-1].range_mm;
        car[k].intensity <= car[k-1].intensity;
        if (k == ST_MASK + 1) begin
          car[k].masked <= mask_w;
        end else begin
          car[k].masked <= car[k-1].masked;
        end
      end
    end
  end

  lpmf_window #(
    .NUM_WINDOWS (NUM_WINDOWS)
  ) u_window (
    .clk      (clk),
    .stage_en (en[ST_MASK:ST_SLOT+1]),
    .slot     (car[ST_SLOT].slot),
    .count    (count1),
    .windows  (win_reg[NUM_WINDOWS-1:0]),
    .masked   (mask_w)
  );

  lpmf_sincos u_sincos (
    .clk      (clk),
    .stage_en (en[ST_TRIG:ST_SLOT+1]),
    .slot     (car[ST_SLOT].slot),
    .step     (step_reg),
    .sin_q15  (sin_w),
    .cos_q15  (cos_w)
  );

  lpmf_body u_body (
    .clk      (clk),
    .stage_en (en[ST_HIT:ST_TRIG+1]),
    .range_mm (car[ST_TRIG].range_mm),
    .sin_q15  (sin_w),
    .cos_q15  (cos_w),
    .center   (center_reg),
    .radius   (radius_reg),
    .hit      (hit_w)
  );

  // Final decision and output register.
  assign near = (car[ST_HIT].range_mm > NEAR_MM) && (car[ST_HIT].range_mm < FAR_MM);

  always_comb begin
    res_c.slot_index = car[ST_HIT].slot;
    if (car[ST_HIT].masked || (car[ST_HIT].range_mm == '0)) begin
      res_c.range_out_mm = NO_RETURN;
      res_c.intensity_out = '0;
    end else begin
      res_c.range_out_mm = RANGE_OUT_W'(car[ST_HIT].range_mm);
      res_c.intensity_out = car[ST_HIT].intensity;
      if (near && hit_w) begin
        res_c.range_out_mm = NO_RETURN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_q <= res_c;
    end
  end

  assign m_axis_tdata = {(OUT_TDATA_W - $bits(result_t))'(0), out_q};

endmodule

// ===== rtl/lpmf_checker.sv =====
module lpmf_checker
  import lpmf_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result stays offered with the same data.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result offered right after reset");

  // With the output free to move, every stage has room for a new point.
  a_room: assert property (@(posedge clk) disable iff (rst)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input held off while the output moves");

  // A zero range is always turned into no-return.
  a_no_zero_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[27:12] != 16'd0)
    else $error("zero range passed to the output");

endmodule

bind lidar_point_mask_filter lpmf_checker u_lpmf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb.sv =====
module tb;
  import lpmf_pkg::*;

  localparam int CLK_HALF = 2;
  localparam int RESET_CYCLES = 6;
  localparam int LATENCY = NUM_STAGES;
  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_LIMIT = 20000;
  localparam int STALL_CYCLES = 120;
  localparam int SCAN_MAX = 4096;
  localparam int NUM_REGS = REG_ANGLE_STEP + 1;
  localparam int DIR_TYPED = 1;
  localparam int DIR_PREDICT = 0;

  // Quarter-wave sine in Q1.15, one entry per whole degree.
  localparam int SINE_DEG [91] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  typedef struct {
    point_t pt;
    bit typed;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // point_index, point_count, range_mm, intensity
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // slot_index, range_out_mm, intensity_out, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Register shadow, results still owed by the block, and run statistics.
  logic [31:0] cfg_regs [NUM_REGS];
  result_t filtered_due [$];
  dir_row_t dir_rows [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic recv_hold = 1'b0;
  bit pressure_go = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int points_sent = 0;
  int phases_run = 0;
  int scan_count = 1;
  int scan_pos = 0;
  int scan_left = 0;

  lidar_point_mask_filter dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin : clock_gen
    forever #CLK_HALF clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (errors < 20) $display("MISMATCH: %s", what);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [11:0] slot,
                             input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("slot %0d %s: got %0d, want %0d", slot, name, got, want));
    end
  endtask

  // Quarter-wave sine of 0..9000 centidegrees, interpolated between degrees; sine_cd extends it to 0..35999.
  function automatic int quarter_q15(input int unsigned u);
    int unsigned d, f;
    if (u >= QUAD_CD) return 32768;
    d = u / 100;
    f = u % 100;
    return SINE_DEG[d] + ((SINE_DEG[d+1] - SINE_DEG[d]) * f + ROUND_HALF) / 100;
  endfunction

  function automatic int sine_cd(input int unsigned a);
    int unsigned quad, rem;
    int v;
    quad = (a / QUAD_CD) % 4;
    rem = a % QUAD_CD;
    v = (quad % 2 == 1) ? quarter_q15(QUAD_CD - rem) : quarter_q15(rem);
    return (quad >= 2) ? -v : v;
  endfunction

  // Filtered point as the block should produce it under the current registers.
  function automatic result_t filter_point(input point_t pt);
    result_t r;
    longint cnt, slot, pos, lo, hi, rng, step, x, y, cx, cy, dx, dy, rr;
    logic [11:0] slot12;
    int unsigned ang;
    bit masked;
    cnt = pt.point_count;
    if (cnt > SCAN_MAX) cnt = SCAN_MAX;
    slot12 = 12'(cnt - 1 - pt.point_index);
    slot = slot12;
    pos = 3600 * slot;
    masked = 1'b0;
    for (int w = 0; w < WIN_REGS; w++) begin
      lo = cfg_regs[REG_WINDOW_A + w][15:0];
      hi = cfg_regs[REG_WINDOW_A + w][31:16];
      if (hi > lo && pos >= lo * cnt && pos < hi * cnt) masked = 1'b1;
    end
    r.slot_index = slot12;
    if (masked || pt.range_mm == 0) begin
      r.range_out_mm = NO_RETURN;
      r.intensity_out = '0;
    end else begin
      r.range_out_mm = 16'(pt.range_mm);
      r.intensity_out = pt.intensity;
      if (pt.range_mm > NEAR_MM && pt.range_mm < FAR_MM) begin
        // Polar to Cartesian in mm*2^15, then the exact circle test.
        step = cfg_regs[REG_ANGLE_STEP][11:0];
        ang = int'((slot * step) % FULL_CD);
        rng = pt.range_mm;
        x = rng * sine_cd((ang + QUAD_CD) % FULL_CD);
        y = rng * sine_cd(ang);
        cx = $signed(cfg_regs[REG_BODY_CENTER][15:0]);
        cy = $signed(cfg_regs[REG_BODY_CENTER][31:16]);
        dx = x - cx * 32768;
        dy = y - cy * 32768;
        rr = cfg_regs[REG_BODY_RADIUS][10:0];
        rr = rr * 32768;
        if (dx * dx + dy * dy < rr * rr) r.range_out_mm = NO_RETURN;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] reg_mask(input logic [2:0] idx);
    case (idx)
      REG_BODY_RADIUS: return 32'h0000_07FF;
      REG_ANGLE_STEP: return 32'h0000_0FFF;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // APB transfers: setup cycle, then access until pready. The select stays
  // up between transfers and is released by the caller.
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic apb_read(input logic [2:0] idx, output logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    value = prdata;
  endtask

  task automatic check_readback();
    logic [31:0] got;
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_read(3'(i), got);
      if (got !== cfg_regs[i]) begin
        report_mismatch($sformatf("register %0d reads %h, expected %h", i, got, cfg_regs[i]));
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_config(input logic [31:0] wa, input logic [31:0] wb,
                             input logic [31:0] wc, input logic [31:0] wd,
                             input logic [31:0] we, input logic [10:0] radius,
                             input logic [31:0] center, input logic [11:0] step);
    logic [31:0] vals [NUM_REGS];
    vals = '{wa, wb, wc, wd, we, 32'(radius), center, 32'(step)};
    for (int i = 0; i < NUM_REGS; i++) begin
      apb_write(3'(i), vals[i]);
      cfg_regs[i] = vals[i] & reg_mask(3'(i));
    end
    check_readback();
    phases_run++;
  endtask

  function automatic logic [31:0] random_window();
    logic [15:0] lo, hi;
    if ($urandom_range(9) < 3) return $urandom;
    lo = 16'($urandom_range(0, 3600));
    hi = 16'($urandom_range(0, 3600));
    return {hi, lo};
  endfunction

  task automatic random_config();
    int cx, cy;
    logic [31:0] center;
    cx = int'($urandom_range(0, 2400)) - 1200;
    cy = int'($urandom_range(0, 2400)) - 1200;
    center = ($urandom_range(9) == 0) ? $urandom : {16'(cy), 16'(cx)};
    load_config(random_window(), random_window(), random_window(), random_window(),
                random_window(), 11'($urandom_range(0, 2047)), center,
                12'($urandom_range(0, 4095)));
  endtask

  // One input transfer, after a random gap; the expectation is queued on
  // acceptance.
  task automatic send_point(input point_t pt, input result_t due);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= IN_TDATA_W'({$urandom, $urandom});
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= pt;
    do @(posedge clk); while (!s_axis_tready);
    filtered_due.push_back(due);
    points_sent++;
  endtask

  // Mostly stretches of consecutive points of a plausible scan, with noise
  // points of any bit pattern in between.
  task automatic next_point(output point_t pt);
    int pick;
    if (scan_left == 0 && $urandom_range(99) < 25) begin
      pt.point_index = 12'($urandom);
      pick = $urandom_range(9);
      case (pick)
        0: pt.point_count = 13'd0;
        1: pt.point_count = 13'h1FFF;
        2: pt.point_count = 13'd4096;
        3: pt.point_count = 13'd4097;
        default: pt.point_count = 13'($urandom);
      endcase
      pt.range_mm = 15'($urandom);
      pt.intensity = 8'($urandom);
    end else begin
      if (scan_left == 0) begin
        case ($urandom_range(5))
          0: scan_count = 360;
          1: scan_count = 720;
          2: scan_count = 3600;
          3: scan_count = 4096;
          4: scan_count = 1000;
          default: scan_count = $urandom_range(1, 4096);
        endcase
        scan_pos = $urandom_range(0, scan_count - 1);
        scan_left = $urandom_range(1, 48);
      end
      pt.point_index = 12'(scan_pos);
      pt.point_count = 13'(scan_count);
      pick = $urandom_range(99);
      if (pick < 10) pt.range_mm = '0;
      else if (pick < 55) pt.range_mm = 15'($urandom_range(40, 1100));
      else pt.range_mm = 15'($urandom_range(1, 25000));
      pt.intensity = 8'($urandom);
      scan_pos++;
      scan_left--;
      if (scan_pos >= scan_count) scan_left = 0;
    end
  endtask

  task automatic wait_drain();
    while (filtered_due.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input bit squeeze);
    point_t pt;
    for (int i = 0; i < n; i++) begin
      next_point(pt);
      if (squeeze && i == 40) pressure_go = 1'b1;
      send_point(pt, filter_point(pt));
    end
    s_axis_tvalid <= 1'b0;
    wait_drain();
  endtask

  task automatic add_row(input int idx, input int cnt, input int rng, input int inten,
                         input int typed, input int slot, input int rout, input int iout);
    dir_row_t row;
    row.pt.point_index = 12'(idx);
    row.pt.point_count = 13'(cnt);
    row.pt.range_mm = 15'(rng);
    row.pt.intensity = 8'(inten);
    row.typed = (typed == DIR_TYPED);
    row.want.slot_index = 12'(slot);
    row.want.range_out_mm = 16'(rout);
    row.want.intensity_out = 8'(iout);
    dir_rows.push_back(row);
  endtask

  // Result side: compare each transfer with the oldest expectation and
  // choose the ready for the next cycle.
  always @(posedge clk) begin : result_sink
    result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(result_t)-1:0];
      if (filtered_due.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", m_axis_tdata));
      end else begin
        want = filtered_due.pop_front();
        check_field("slot_index", want.slot_index, 16'(got.slot_index), 16'(want.slot_index));
        check_field("range_out_mm", want.slot_index, got.range_out_mm, want.range_out_mm);
        check_field("intensity_out", want.slot_index, 16'(got.intensity_out),
                    16'(want.intensity_out));
        check_field("zero fill", want.slot_index,
                    16'(m_axis_tdata[OUT_TDATA_W-1:$bits(result_t)]), 16'd0);
      end
      results_seen++;
    end
    m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
  end

  // Long receiver hold-off so the pipeline fills and stalls its input.
  initial begin : backpressure
    wait (pressure_go);
    @(posedge clk);
    recv_hold <= 1'b1;
    repeat (STALL_CYCLES) @(posedge clk);
    recv_hold <= 1'b0;
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("Timeout with %0d results still pending.", filtered_due.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int guard;
    for (int i = 0; i < NUM_REGS; i++) cfg_regs[i] = '0;
    cfg_regs[REG_BODY_RADIUS] = 32'(RADIUS_RESET);
    cfg_regs[REG_ANGLE_STEP] = 32'(STEP_RESET);
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_readback();

    // Directed points under the reset registers: radius 200, center at the
    // origin, step of one degree, all windows off.
    send_idle_pct = 16;
    recv_idle_pct = 46;
    // Zero range, far range, far limit, self-hits around the near limit.
    add_row(0, 1, 0, 255, DIR_TYPED, 0, NO_RETURN, 0);
    add_row(0, 4096, 25000, 170, DIR_TYPED, 4095, 25000, 170);
    add_row(4095, 4096, 1000, 1, DIR_TYPED, 0, 1000, 1);
    add_row(4095, 4096, 100, 77, DIR_TYPED, 0, NO_RETURN, 77);
    add_row(4095, 4096, 60, 5, DIR_TYPED, 0, 60, 5);
    add_row(4095, 4096, 61, 6, DIR_TYPED, 0, NO_RETURN, 6);
    add_row(4095, 4096, 199, 7, DIR_TYPED, 0, NO_RETURN, 7);
    // A point exactly on the body circle is not inside it.
    add_row(4095, 4096, 200, 8, DIR_TYPED, 0, 200, 8);
    // Counts above the maximum saturate; range above the sensor limit passes.
    add_row(0, 8191, 32767, 0, DIR_TYPED, 4095, 32767, 0);
    add_row(4095, 4097, 5000, 9, DIR_TYPED, 0, 5000, 9);
    // Count zero and indexes past the count wrap the slot.
    add_row(0, 0, 500, 10, DIR_PREDICT, 0, 0, 0);
    add_row(100, 50, 500, 11, DIR_PREDICT, 0, 0, 0);
    add_row(4095, 1, 150, 12, DIR_PREDICT, 0, 0, 0);
    // Near points at the quadrant boundaries and one full turn.
    add_row(4005, 4096, 150, 13, DIR_PREDICT, 0, 0, 0);
    add_row(3915, 4096, 150, 14, DIR_PREDICT, 0, 0, 0);
    add_row(3825, 4096, 150, 15, DIR_PREDICT, 0, 0, 0);
    add_row(3735, 4096, 150, 16, DIR_PREDICT, 0, 0, 0);
    add_row(2000, 4096, 500, 0, DIR_PREDICT, 0, 0, 0);
    add_row(3000, 3600, 999, 255, DIR_PREDICT, 0, 0, 0);
    foreach (dir_rows[i]) begin
      send_point(dir_rows[i].pt, dir_rows[i].typed ? dir_rows[i].want
                                                   : filter_point(dir_rows[i].pt));
    end
    s_axis_tvalid <= 1'b0;
    wait_drain();

    // Ordinary windows, some of them disabled by max not above min.
    load_config({16'd900, 16'd0}, {16'd1900, 16'd1800}, {16'd1000, 16'd2000},
                {16'd500, 16'd500}, {16'd3600, 16'd3000}, 11'd300,
                {16'hFFCE, 16'd100}, 12'd100);
    run_phase(250, 1'b1);
    // Extremes: one window masking everything, largest radius, far center.
    load_config({16'hFFFF, 16'h0000}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 11'd2047, {16'h8000, 16'h7FFF}, 12'd3600);
    run_phase(100, 1'b0);
    load_config(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 11'd0, 32'h0, 12'd4095);
    run_phase(150, 1'b0);

    send_idle_pct = 46;
    recv_idle_pct = 16;
    // Narrow windows at the ends and inside the turn, a body of radius 2000, smallest step.
    load_config({16'd1, 16'd0}, {16'd3600, 16'd3599}, {16'd1801, 16'd1799},
                {16'd0, 16'hFFFF}, {16'd2701, 16'd2700}, 11'd2000, 32'h0, 12'd1);
    run_phase(150, 1'b0);
    repeat (2) begin
      random_config();
      run_phase(140, 1'b0);
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) begin
      random_config();
      run_phase(140, 1'b0);
    end

    guard = 0;
    while (filtered_due.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 8) @(posedge clk);
    if (filtered_due.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", filtered_due.size()));
    end

    $display("Run covered %0d points over %0d register settings, %0d results compared.",
             points_sent, phases_run, results_seen);
    $display("Stalls were applied on both sides, with one long output hold-off, then full rate.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
